[rtl/wsm_pkg.sv]
// Package for the word substring matcher: defaults, character codes,
// configuration register indexes and the match flag struct.
// No dependencies.
`timescale 1ns / 1ps

package wsm_pkg;

	localparam int PATTERN_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF    = 32;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_LEN_W   = 4;
	localparam int FIELD_W     = 16;
	localparam int TOTAL_W     = 32;
	localparam int OUT_TDATA_W = 152;

	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_SPACE = 8'h20;

	typedef enum logic [0:0] {
		CFG_PATTERN_BYTES  = 1'b0,
		CFG_PATTERN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic fwd;
		logic rev;
	} match_t;

endpackage

[rtl/wsm_match.sv]
// Window compare: checks the newest bytes of the character window against
// the pattern, forward and reversed. Depends on wsm_pkg.
`timescale 1ns / 1ps

module wsm_match import wsm_pkg::*; #(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF
) (
	input  logic [PATTERN_BYTES*8-1:0]         window,
	input  logic [PATTERN_BYTES*8-1:0]         pattern,
	input  logic [$clog2(PATTERN_BYTES+1)-1:0] len,
	output match_t                             match
);

	// window byte j is the j-th newest character of the word
	always_comb begin
		match.fwd = 1'b1;
		match.rev = 1'b1;
		for (int j = 0; j < PATTERN_BYTES; j++) begin
			for (int k = 0; k < PATTERN_BYTES; k++) begin
				if (window[j*8 +: 8] != pattern[k*8 +: 8]) begin
					// forward: the last pattern character sits in the newest byte
					if (j < len && j + k + 1 == len)
						match.fwd = 1'b0;
					if (j < len && j == k)
						match.rev = 1'b0;
				end
			end
		end
	end

endmodule

[rtl/word_substring_matcher.sv]
// Top level of the word substring matcher: input register, word state,
// result register and configuration. Depends on wsm_pkg and wsm_match.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Contents
// s_*       | in        | s_tvalid/s_tready  | text_char in tdata, end_of_text on tlast
// m_*       | out       | m_tvalid/m_tready  | word report in tdata, word_valid on tuser,
//           |           |                    | is_final on tlast
// cfg_*     | in        | cfg_we             | pattern_bytes (0), pattern_length (1)
//
// One item per cycle sustained while the result side is not stalled; an item passes
// through the input register, then through the window compare into the
// result register. Reset clears the word state, the totals and the pattern.
// A stalled result holds the input register, which then stalls the input side.

module word_substring_matcher import wsm_pkg::*; #(
	parameter int PATTERN_BYTES = PATTERN_BYTES_DEF,
	parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,  // [7:0] text_char
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [15:0] line_number, [31:16] word_index, [47:32] word_length,
	// [48] begins_with, [49] has_pattern, [50] has_reversed,
	// [82:51] total_begins, [114:83] total_contains, [146:115] total_reversed,
	// [151:147] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,  // [0] word_valid
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [0:0]             cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int WIN_W = PATTERN_BYTES * 8;
	localparam int LEN_W = $clog2(PATTERN_BYTES + 1);

	// configuration
	logic [WIN_W-1:0] pattern_q;
	logic [LEN_W-1:0] len_q;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// word state
	logic [WIN_W-1:0]      window_q;
	logic [FIELD_W-1:0]    chars_q;
	logic [FIELD_W-1:0]    line_q;
	logic [FIELD_W-1:0]    index_q;
	logic [2:0]            flags_q;
	logic [COUNT_BITS-1:0] cnt_beg_q, cnt_con_q, cnt_rev_q;

	// result register
	logic m_tvalid_q;

	logic s_acc, adv;
	logic is_ws, is_nl, close, emit;
	logic [WIN_W-1:0]      win_shift, win_nx;
	logic [FIELD_W-1:0]    chars_nx, line_inc, line_nx, index_inc, index_nx;
	logic [FIELD_W-1:0]    r_line, r_index, r_len;
	logic [2:0]            flags_nx, r_flags;
	logic [COUNT_BITS-1:0] beg_nx, con_nx, rev_nx;
	logic [CFG_LEN_W-1:0]  cfg_len;
	match_t                match;

	assign s_acc    = s_tvalid && s_tready;
	assign adv      = valid_s1 && (!m_tvalid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = m_tvalid_q;

	// configuration writes; clamp the length to the pattern storage
	assign cfg_len = cfg_data[CFG_LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			len_q     <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_BYTES:  pattern_q <= cfg_data[WIN_W-1:0];
				CFG_PATTERN_LENGTH: begin
					if (int'(cfg_len) > PATTERN_BYTES)
						len_q <= LEN_W'(PATTERN_BYTES);
					else
						len_q <= LEN_W'(cfg_len);
				end
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_acc)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	assign win_shift = WIN_W'({window_q, char_s1});

	wsm_match #(
		.PATTERN_BYTES(PATTERN_BYTES)
	) u_match (
		.window (win_shift),
		.pattern(pattern_q),
		.len    (len_q),
		.match  (match)
	);

	always_comb begin
		is_ws = (char_s1 == CHAR_SPACE) || (char_s1 >= CHAR_TAB && char_s1 <= CHAR_CR);
		is_nl = (char_s1 == CHAR_NL);

		// add a non-whitespace character to the word
		win_nx   = is_ws ? window_q : win_shift;
		chars_nx = chars_q;
		flags_nx = flags_q;
		if (!is_ws) begin
			if (chars_q != '1)
				chars_nx = chars_q + FIELD_W'(1);
			if (len_q != '0 && chars_nx >= FIELD_W'(len_q))
				flags_nx = flags_q | {match.rev, match.fwd,
					match.fwd && chars_nx == FIELD_W'(len_q)};
		end

		close   = (is_ws || last_s1) && chars_nx != '0;
		emit    = close || last_s1;
		r_flags = (len_q == '0) ? 3'b111 : flags_nx;

		beg_nx = cnt_beg_q;
		con_nx = cnt_con_q;
		rev_nx = cnt_rev_q;
		if (close && r_flags[0] && cnt_beg_q != '1)
			beg_nx = cnt_beg_q + COUNT_BITS'(1);
		if (close && r_flags[1] && cnt_con_q != '1)
			con_nx = cnt_con_q + COUNT_BITS'(1);
		if (close && r_flags[2] && cnt_rev_q != '1)
			rev_nx = cnt_rev_q + COUNT_BITS'(1);

		line_inc  = (line_q == '1) ? line_q : line_q + FIELD_W'(1);
		index_inc = (index_q == '1) ? index_q : index_q + FIELD_W'(1);

		// newline closes the word on the current line, then advances
		line_nx  = is_nl ? line_inc : line_q;
		index_nx = is_nl ? '0 : (close ? index_inc : index_q);

		r_line  = close ? line_q : line_nx;
		r_index = close ? index_q : index_nx;
		r_len   = close ? chars_nx : '0;
	end

	// word state; the final item returns it to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			chars_q   <= '0;
			line_q    <= FIELD_W'(1);
			index_q   <= '0;
			flags_q   <= '0;
			cnt_beg_q <= '0;
			cnt_con_q <= '0;
			cnt_rev_q <= '0;
		end else if (adv) begin
			if (last_s1) begin
				window_q  <= '0;
				chars_q   <= '0;
				line_q    <= FIELD_W'(1);
				index_q   <= '0;
				flags_q   <= '0;
				cnt_beg_q <= '0;
				cnt_con_q <= '0;
				cnt_rev_q <= '0;
			end else begin
				window_q  <= close ? '0 : win_nx;
				chars_q   <= close ? '0 : chars_nx;
				flags_q   <= close ? '0 : flags_nx;
				line_q    <= line_nx;
				index_q   <= index_nx;
				cnt_beg_q <= beg_nx;
				cnt_con_q <= con_nx;
				cnt_rev_q <= rev_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (adv && emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			m_tdata <= {5'b0, TOTAL_W'(rev_nx), TOTAL_W'(con_nx), TOTAL_W'(beg_nx),
				close ? r_flags : 3'b000, r_len, r_index, r_line};
			m_tuser <= close;
			m_tlast <= last_s1;
		end
	end

`ifndef SYNTH
	// a report without a word only comes from the end of text
	a_bare_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata[50:32] == '0)
		else $error("bare result without end of text or with nonzero length/flags");

	// the end of text leaves the word state at its reset values
	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> line_q == FIELD_W'(1) && chars_q == '0 && index_q == '0)
		else $error("word state not cleared after end of text");

	// a result is loaded only while the result register is free or draining
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv && emit |-> !m_tvalid_q || m_tready)
		else $error("result register overwritten while stalled");
`endif

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for word_substring_matcher: streams text bytes, predicts
// every word report and compares each reported field. Depends on wsm_pkg and the
// word_substring_matcher RTL.

module tb;
	import wsm_pkg::*;

	localparam logic [7:0] CHAR_VT = 8'h0B;
	localparam logic [7:0] CHAR_FF = 8'h0C;
	localparam int PIPE_SLACK  = 6;
	localparam int CYCLE_LIMIT = 2_000_000;

	typedef struct packed {
		logic [15:0] line_number;
		logic [15:0] word_index;
		logic [15:0] word_length;
		logic        begins_with;
		logic        has_pattern;
		logic        has_reversed;
		logic        word_valid;
		logic        is_final;
		logic [31:0] total_begins;
		logic [31:0] total_contains;
		logic [31:0] total_reversed;
	} word_report_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [7:0]             s_tdata = '0;
	logic                   s_tlast = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;
	logic                   cfg_we = 1'b0;
	cfg_reg_t               cfg_index = CFG_PATTERN_BYTES;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	// Predicted state of the matcher
	logic [CFG_DATA_W-1:0] pattern_reg;
	logic [CFG_LEN_W-1:0]  pattern_len_reg;
	logic [63:0]           char_history;
	logic [15:0]           open_chars;
	logic [15:0]           line_count;
	logic [15:0]           words_on_line;
	logic [2:0]            sticky_flags;
	logic [31:0]           begins_total;
	logic [31:0]           contains_total;
	logic [31:0]           reversed_total;

	word_report_t pending_reports[$];
	word_report_t oldest_report;
	int           error_count = 0;
	int           items_sent = 0;
	int           cycle_count = 0;
	int           hold_off_request = 0;
	bit           send_idle_on = 1'b1;
	bit           recv_idle_on = 1'b1;

	word_substring_matcher dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic bit is_space(logic [7:0] c);
		return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

	function automatic logic [15:0] bump16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	function automatic logic [31:0] bump_total(logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

	function automatic int active_len();
		return (pattern_len_reg > PATTERN_BYTES_DEF) ? PATTERN_BYTES_DEF : int'(pattern_len_reg);
	endfunction

	// Forward: the newest byte lines up with the last pattern character.
	function automatic bit window_hit(int len, bit reversed);
		for (int j = 0; j < len; j++) begin
			if (char_history[8*j +: 8] != pattern_reg[8*(reversed ? j : len-1-j) +: 8])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void clear_text();
		char_history   = '0;
		open_chars     = '0;
		line_count     = 16'd1;
		words_on_line  = '0;
		sticky_flags   = '0;
		begins_total   = '0;
		contains_total = '0;
		reversed_total = '0;
	endfunction

	function automatic void predict_byte(logic [7:0] c, logic eot);
		int           len;
		bit           ws;
		bit           closed;
		logic [2:0]   hits;
		word_report_t r;
		len = active_len();
		ws = is_space(c);
		closed = 1'b0;
		r = '0;
		if (!ws) begin
			char_history = {char_history[55:0], c};
			open_chars = bump16(open_chars);
			if (len > 0 && open_chars >= len) begin
				if (open_chars == len && window_hit(len, 1'b0)) sticky_flags[0] = 1'b1;
				if (window_hit(len, 1'b0)) sticky_flags[1] = 1'b1;
				if (window_hit(len, 1'b1)) sticky_flags[2] = 1'b1;
			end
		end
		if ((ws || eot) && open_chars != 0) begin
			closed = 1'b1;
			hits = (len == 0) ? 3'b111 : sticky_flags;
			r.line_number = line_count;
			r.word_index  = words_on_line;
			r.word_length = open_chars;
			{r.has_reversed, r.has_pattern, r.begins_with} = hits;
			if (hits[0]) begins_total = bump_total(begins_total);
			if (hits[1]) contains_total = bump_total(contains_total);
			if (hits[2]) reversed_total = bump_total(reversed_total);
			words_on_line = bump16(words_on_line);
			open_chars = '0;
			sticky_flags = '0;
			char_history = '0;
		end
		// a newline closes its word first, then starts the next line
		if (ws && c == CHAR_NL) begin
			line_count = bump16(line_count);
			words_on_line = '0;
		end
		if (closed || eot) begin
			if (!closed) begin
				r.line_number = line_count;
				r.word_index  = words_on_line;
			end
			r.word_valid     = closed;
			r.is_final       = eot;
			r.total_begins   = begins_total;
			r.total_contains = contains_total;
			r.total_reversed = reversed_total;
			pending_reports = {pending_reports, r};
		end
		if (eot) clear_text();
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) return 0;
		if (roll < 93) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	task automatic send_byte(logic [7:0] c, logic eot);
		int gap;
		gap = send_idle_on ? pick_gap() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		s_tlast  <= eot;
		do @(posedge clk); while (!s_tready);
		predict_byte(c, eot);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
	endtask

	// Drop valid and hold until every predicted report is back.
	task automatic wait_for_reports();
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (PIPE_SLACK) @(posedge clk);
	endtask

	task automatic write_pattern(logic [63:0] chars, logic [3:0] length);
		logic [CFG_DATA_W-1:0] len_word;
		wait_for_reports();
		len_word = {$urandom, $urandom};
		len_word[CFG_LEN_W-1:0] = length;
		cfg_we    <= 1'b1;
		cfg_index <= CFG_PATTERN_BYTES;
		cfg_data  <= chars;
		@(posedge clk);
		cfg_index <= CFG_PATTERN_LENGTH;
		cfg_data  <= len_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		pattern_reg = chars;
		pattern_len_reg = length;
	endtask

	function automatic logic [7:0] word_char();
		logic [7:0] c;
		int         roll;
		roll = $urandom_range(0, 9);
		if (roll < 6 && active_len() > 0)
			c = pattern_reg[8*$urandom_range(0, active_len()-1) +: 8];
		else if (roll < 8)
			c = 8'("a" + $urandom_range(0, 2));
		else
			c = 8'($urandom_range(0, 255));
		return is_space(c) ? "a" : c;
	endfunction

	// Mostly words built around the pattern, some noise and stray end markers.
	task automatic send_random_text(int count);
		logic [7:0] chars[$];
		logic [7:0] separators[6];
		int         stop_at;
		int         len;
		int         roll;
		int         keep;
		bit         last_eot;
		separators = '{CHAR_SPACE, CHAR_TAB, CHAR_NL, CHAR_VT, CHAR_FF, CHAR_CR};
		stop_at = items_sent + count;
		while (items_sent < stop_at) begin
			len = active_len();
			if ($urandom_range(0, 99) < 8) begin
				send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 49) == 0);
			end else begin
				chars.delete();
				repeat ($urandom_range(0, 2)) chars = {chars, word_char()};
				roll = $urandom_range(0, 3);
				keep = (roll == 3) ? $urandom_range(0, len) : len;
				for (int i = 0; i < keep && roll != 2; i++)
					chars = {chars, pattern_reg[8*((roll == 1) ? len-1-i : i) +: 8]};
				repeat ($urandom_range(0, 2)) chars = {chars, word_char()};
				if ($urandom_range(0, 19) == 0) repeat (20) chars = {chars, word_char()};
				if (chars.size() == 0) chars = {chars, word_char()};
				last_eot = $urandom_range(0, 49) == 0;
				foreach (chars[i]) send_byte(chars[i], last_eot && i == chars.size() - 1);
				if (!last_eot) begin
					repeat ($urandom_range(1, 2))
						send_byte(separators[$urandom_range(0, 5)], $urandom_range(0, 39) == 0);
				end
			end
		end
	endtask

	// Reset pattern is empty, so every word matches.
	task automatic test_empty_pattern();
		send_text("a b");
		send_byte("c", 1'b1);
	endtask

	task automatic test_match_flags();
		write_pattern(64'h0000_0000_0063_6261, 4'd3);  // "abc"
		send_text("abcx");
		send_byte(CHAR_TAB, 1'b0);
		send_text("xcba");
		send_byte(CHAR_NL, 1'b0);
		send_text("zabcba");
		send_byte(CHAR_SPACE, 1'b0);
		send_text("ab");
		send_byte(CHAR_FF, 1'b0);
		send_byte(CHAR_CR, 1'b0);
		send_byte(CHAR_VT, 1'b0);
		send_byte(CHAR_SPACE, 1'b1);
		send_byte(CHAR_SPACE, 1'b1);  // no open word: bare end marker
	endtask

	task automatic test_long_pattern();
		write_pattern('1, 4'd15);
		repeat (8) send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic test_backpressure();
		wait_for_reports();
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		hold_off_request = 300;
		send_random_text(150);
		wait_for_reports();
		send_random_text(60);
	endtask

	task automatic test_random_text();
		logic [63:0] chars;
		logic [3:0]  length;
		for (int phase = 0; phase < 10; phase++) begin
			if (phase == 0) begin
				chars = '0;
				length = 4'd8;
			end else if (phase == 1) begin
				chars = '1;
				length = 4'd15;
			end else begin
				case ($urandom_range(0, 5))
					0: chars = '0;
					1: chars = '1;
					2: chars = {$urandom, $urandom};
					default: begin
						for (int i = 0; i < 8; i++)
							chars[8*i +: 8] = 8'("a" + $urandom_range(0, 2));
					end
				endcase
				case ($urandom_range(0, 4))
					0: length = 4'd0;
					1: length = 4'd8;
					2: length = 4'd15;
					default: length = 4'($urandom_range(1, 7));
				endcase
			end
			write_pattern(chars, length);
			send_idle_on = $urandom_range(0, 3) != 0;
			recv_idle_on = $urandom_range(0, 3) != 0;
			send_random_text(175);
		end
	endtask

	initial begin : receiver
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_request > 0) begin
				stall_left = hold_off_request;
				hold_off_request = 0;
			end
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (recv_idle_on) stall_left = pick_gap();
			end
		end
	end

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$display("%0t ns: unexpected word report, tdata 0x%0h", $time, m_tdata);
				error_count++;
			end else begin
				oldest_report = pending_reports.pop_front();
				check_field("line_number", oldest_report.line_number, m_tdata[15:0]);
				check_field("word_index", oldest_report.word_index, m_tdata[31:16]);
				check_field("word_length", oldest_report.word_length, m_tdata[47:32]);
				check_field("begins_with", oldest_report.begins_with, m_tdata[48]);
				check_field("has_pattern", oldest_report.has_pattern, m_tdata[49]);
				check_field("has_reversed", oldest_report.has_reversed, m_tdata[50]);
				check_field("total_begins", oldest_report.total_begins, m_tdata[82:51]);
				check_field("total_contains", oldest_report.total_contains, m_tdata[114:83]);
				check_field("total_reversed", oldest_report.total_reversed, m_tdata[146:115]);
				check_field("tdata padding", '0, m_tdata[151:147]);
				check_field("word_valid", oldest_report.word_valid, m_tuser);
				check_field("is_final", oldest_report.is_final, m_tlast);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		pattern_reg = '0;
		pattern_len_reg = '0;
		clear_text();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_pattern();
		test_match_flags();
		test_long_pattern();
		test_backpressure();
		test_random_text();
		wait_for_reports();
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

[word_substring_matcher.f]
rtl/wsm_pkg.sv
rtl/wsm_match.sv
rtl/word_substring_matcher.sv
dv/tb.sv
